// File: src/eig2_pkg.sv
// Package with shared constants and types for the 2x2 eigenvalue unit.
package eig2_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IN_W = 32;
   localparam int OUT_W = 40;
   // Discriminant quarter: up to 2^63, kept as 64-bit signed.
   localparam int Q_W = 64;
   localparam int S_W = 32;
   // Radicand of the second square root: root (<= 2^33) shifted by FRAC_BITS.
   localparam int R_W = 64;
   localparam int RS_W = 32;

   // Square-root pipeline stages and result bits resolved in each stage.
   localparam int SQRT_STAGES = 8;
   localparam int SQRT_BITS = 32 / SQRT_STAGES;
   // Front (2), first root, root forming (1), second root, select (1), output (1).
   localparam int PIPE_DEPTH = 2 * SQRT_STAGES + 5;

   typedef logic signed [IN_W-1:0] entry_type;
   typedef logic signed [OUT_W-1:0] value_type;

   // One step of a restoring square root: one result bit per call.
   typedef struct packed {
      logic [63:0] rem;
      logic [31:0] root;
   } sqrt_state_type;

   function automatic sqrt_state_type sqrt_step(sqrt_state_type st, logic [63:0] x, int k);
      logic [65:0] trial;
      sqrt_state_type res;
      logic [65:0] rem2;
      rem2 = {st.rem, x[2*k+1 -: 2]};
      trial = {32'b0, st.root, 2'b01};
      res = st;
      if (rem2 >= trial) begin
         res.rem = 64'(rem2 - trial);
         res.root = {st.root[30:0], 1'b1};
      end else begin
         res.rem = rem2[63:0];
         res.root = {st.root[30:0], 1'b0};
      end
      return res;
   endfunction

endpackage

// File: src/eig2_if.sv
// Valid/ready stream interfaces for requests and responses.
interface eig2_req_if (input logic clock);
   import eig2_pkg::*;
   logic valid;
   logic ready;
   entry_type entry_00;
   entry_type entry_01;
   entry_type entry_10;
   entry_type entry_11;
   modport source (output valid, entry_00, entry_01, entry_10, entry_11, input ready);
   modport sink (input valid, entry_00, entry_01, entry_10, entry_11, output ready);
endinterface

interface eig2_rsp_if (input logic clock);
   import eig2_pkg::*;
   logic valid;
   logic ready;
   value_type value_high;
   value_type value_low;
   logic distinct_roots;
   logic clamped_negative;
   modport source (output valid, value_high, value_low, distinct_roots, clamped_negative,
                   input ready);
   modport sink (input valid, value_high, value_low, distinct_roots, clamped_negative,
                 output ready);
endinterface

interface eig2_csr_if (input logic clock);
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// File: src/eig2_sqrt_pipe.sv
// Pipelined 64-bit integer square root, four result bits per stage.
module eig2_sqrt_pipe (
   input  logic        clock,
   input  logic        advance,
   input  logic [63:0] radicand,
   output logic [31:0] root
);
   import eig2_pkg::*;

   sqrt_state_type st_ff [SQRT_STAGES];
   logic [63:0] x_ff [SQRT_STAGES];
   sqrt_state_type st_in [SQRT_STAGES];

   always_comb begin
      sqrt_state_type cur;
      for (int s = 0; s < SQRT_STAGES; s++) begin
         if (s == 0) begin
            cur = '0;
         end else begin
            cur = st_ff[s-1];
         end
         for (int b = 0; b < SQRT_BITS; b++) begin
            cur = sqrt_step(cur, (s == 0) ? radicand : x_ff[s-1], 31 - s*SQRT_BITS - b);
         end
         st_in[s] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < SQRT_STAGES; s++) begin
            st_ff[s] <= st_in[s];
            x_ff[s] <= (s == 0) ? radicand : x_ff[s-1];
         end
      end
   end

   assign root = st_ff[SQRT_STAGES-1].root;
endmodule

// File: src/eig2_front.sv
// Front stages: trace half and quarter discriminant, registered.
module eig2_front (
   input  logic                clock,
   input  logic                advance,
   input  eig2_pkg::entry_type entry_00,
   input  eig2_pkg::entry_type entry_01,
   input  eig2_pkg::entry_type entry_10,
   input  eig2_pkg::entry_type entry_11,
   output logic signed [63:0]  q,
   output logic                h_odd,
   output logic signed [33:0]  half
);
   import eig2_pkg::*;

   logic [32:0] hu_ff;
   logic signed [63:0] bc_ff;
   logic signed [33:0] half1_ff;
   logic signed [63:0] q_ff;
   logic odd_ff;
   logic signed [33:0] half2_ff;
   logic signed [32:0] h;
   logic signed [32:0] t;
   logic [65:0] sq;

   assign h = 33'(entry_00) - 33'(entry_11);
   assign t = 33'(entry_00) + 33'(entry_11);
   assign sq = 66'(hu_ff) * 66'(hu_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         hu_ff <= h[32] ? 33'(-h) : 33'(h);
         bc_ff <= 64'(entry_01) * 64'(entry_10);
         half1_ff <= 34'(t >>> 1);
         q_ff <= 64'(sq >> 2) + bc_ff;
         odd_ff <= hu_ff[0];
         half2_ff <= half1_ff;
      end
   end

   assign q = q_ff;
   assign h_odd = odd_ff;
   assign half = half2_ff;
endmodule

// File: src/eigenvalues_2x2_quadratic_unit.sv
// Top level of the 2x2 closed-form eigenvalue unit.
// Requests carry the four signed Q16.16 entries of one matrix; responses carry
// both roots in Q24.16, a distinct-roots flag and a clamp flag. The csr
// channel writes root_mode: 0 returns eigenvalues, 1 returns their square
// roots, negative roots clamped to 0 with the flag set.
// A new request is taken every cycle unless the receiver stalls. The front
// stages form the trace and discriminant, the discriminant square-root pipeline
// follows, a register forms the roots, the second square-root pair follows, then
// a clamp-and-select register and the output register close the pipeline.
// Reset clears all valid bits and root_mode. When the receiver stalls the
// whole pipeline holds; request ready follows response ready, so nothing is
// lost or repeated. csr writes are always ready.
module eigenvalues_2x2_quadratic_unit (
   input  logic       clock,
   input  logic       reset,
   eig2_req_if.sink   req,
   eig2_rsp_if.source rsp,
   eig2_csr_if.sink   csr
);
   import eig2_pkg::*;

   logic mode_ff;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic advance;

   logic signed [63:0] q;
   logic h_odd;
   logic signed [33:0] half;
   logic [31:0] s_root;

   // side data for the first square root
   logic signed [33:0] half_d_ff [SQRT_STAGES];
   logic dist_d_ff [SQRT_STAGES];
   logic dist_c;

   logic signed [34:0] hi_ff, lo_ff;
   logic dist2_ff;
   logic signed [34:0] hi_d_ff [SQRT_STAGES], lo_d_ff [SQRT_STAGES];
   logic dist_e_ff [SQRT_STAGES];
   logic mode_d_ff [SQRT_STAGES+1];
   logic [31:0] rhi, rlo;

   value_type vh_ff, vl_ff;
   logic dist3_ff, clamp_ff;

   assign advance = !vld_ff[PIPE_DEPTH-1] || rsp.ready;
   assign req.ready = advance;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         vld_ff <= '0;
      end else begin
         if (csr.valid) begin
            mode_ff <= csr.data;
         end
         if (advance) begin
            vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req.valid};
         end
      end
   end

   eig2_front u_front (
      .clock(clock), .advance(advance),
      .entry_00(req.entry_00), .entry_01(req.entry_01),
      .entry_10(req.entry_10), .entry_11(req.entry_11),
      .q(q), .h_odd(h_odd), .half(half)
   );

   assign dist_c = (q > 0) || (q == 0 && h_odd);

   eig2_sqrt_pipe u_sqrt_d (
      .clock(clock), .advance(advance),
      .radicand(dist_c ? 64'(q) : 64'd0), .root(s_root)
   );

   logic signed [34:0] sx;
   assign sx = 35'({3'b0, s_root});

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < SQRT_STAGES; i++) begin
            half_d_ff[i] <= (i == 0) ? half : half_d_ff[i-1];
            dist_d_ff[i] <= (i == 0) ? dist_c : dist_d_ff[i-1];
            hi_d_ff[i] <= (i == 0) ? hi_ff : hi_d_ff[i-1];
            lo_d_ff[i] <= (i == 0) ? lo_ff : lo_d_ff[i-1];
            dist_e_ff[i] <= (i == 0) ? dist2_ff : dist_e_ff[i-1];
         end
         hi_ff <= 35'(half_d_ff[SQRT_STAGES-1]) + sx;
         lo_ff <= 35'(half_d_ff[SQRT_STAGES-1]) - sx;
         dist2_ff <= dist_d_ff[SQRT_STAGES-1];
      end
   end

   // Root mode is sampled as each item enters the second square roots and carried to select;
   // config is to change only while idle, which the block does not enforce, so one capture point suffices.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < SQRT_STAGES + 1; i++) begin
            mode_d_ff[i] <= (i == 0) ? mode_ff : mode_d_ff[i-1];
         end
      end
   end

   logic [63:0] rad_hi, rad_lo;
   assign rad_hi = hi_ff[34] ? 64'd0 : (64'(hi_ff) << FRAC_BITS);
   assign rad_lo = lo_ff[34] ? 64'd0 : (64'(lo_ff) << FRAC_BITS);

   eig2_sqrt_pipe u_sqrt_hi (
      .clock(clock), .advance(advance), .radicand(rad_hi), .root(rhi)
   );
   eig2_sqrt_pipe u_sqrt_lo (
      .clock(clock), .advance(advance), .radicand(rad_lo), .root(rlo)
   );

   logic signed [34:0] hx, lx;
   assign hx = hi_d_ff[SQRT_STAGES-1];
   assign lx = lo_d_ff[SQRT_STAGES-1];

   always_ff @(posedge clock) begin
      if (advance) begin
         dist3_ff <= dist_e_ff[SQRT_STAGES-1];
         if (mode_d_ff[SQRT_STAGES]) begin
            vh_ff <= 40'({8'b0, rhi});
            vl_ff <= 40'({8'b0, rlo});
            clamp_ff <= hx[34] || lx[34];
         end else begin
            vh_ff <= 40'(hx);
            vl_ff <= 40'(lx);
            clamp_ff <= 1'b0;
         end
      end
   end

   // final output register stage
   value_type vh_o_ff, vl_o_ff;
   logic dist_o_ff, clamp_o_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         vh_o_ff <= vh_ff;
         vl_o_ff <= vl_ff;
         dist_o_ff <= dist3_ff;
         clamp_o_ff <= clamp_ff;
      end
   end

   assign rsp.valid = vld_ff[PIPE_DEPTH-1];
   assign rsp.value_high = vh_o_ff;
   assign rsp.value_low = vl_o_ff;
   assign rsp.distinct_roots = dist_o_ff;
   assign rsp.clamped_negative = clamp_o_ff;
endmodule

// File: dv/eigenvalues_2x2_quadratic_unit_tb.sv
// Self-checking testbench for the 2x2 closed-form eigenvalue unit.
module eigenvalues_2x2_quadratic_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import eig2_pkg::*;

   typedef struct {
      value_type value_high;
      value_type value_low;
      logic      distinct_roots;
      logic      clamped_negative;
   } roots_type;

   class eig_scoreboard;
      roots_type pending_roots[$];
      bit        root_mode;
      int        errors;

      function automatic logic [63:0] int_sqrt(logic [63:0] x);
         logic [63:0] r;
         logic [63:0] b;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function automatic logic signed [63:0] root_of(logic signed [63:0] r, ref logic clamp);
         if (r < 0) begin
            clamp = 1'b1;
            return 0;
         end
         return $signed(int_sqrt(64'(r) << FRAC_BITS));
      endfunction

      function void note_request(entry_type e00, entry_type e01, entry_type e10,
                                 entry_type e11);
         logic signed [63:0] a, b, c, d, h, q, s, t, half, hi, lo;
         logic [63:0] hu;
         logic distinct, clamp;
         roots_type res;
         a = e00; b = e01; c = e10; d = e11;
         h = a - d;
         hu = (h < 0) ? 64'(-h) : 64'(h);
         q = $signed((hu * hu) >> 2) + b * c;
         distinct = (q > 0) || (q == 0 && hu[0]);
         s = distinct ? $signed(int_sqrt(64'(q))) : 64'sd0;
         t = a + d;
         // Floor division by two for both signs.
         half = t >>> 1;
         hi = half + s;
         lo = half - s;
         clamp = 1'b0;
         if (root_mode) begin
            hi = root_of(hi, clamp);
            lo = root_of(lo, clamp);
         end
         res.value_high = hi[OUT_W-1:0];
         res.value_low = lo[OUT_W-1:0];
         res.distinct_roots = distinct;
         res.clamped_negative = clamp;
         pending_roots = {pending_roots, res};
      endfunction

      function void check_response(value_type vh, value_type vl, logic dr, logic cn);
         roots_type e;
         if (pending_roots.size() == 0) begin
            $error("unexpected response");
            errors++;
            return;
         end
         e = pending_roots.pop_front();
         if (vh !== e.value_high) begin
            $error("value_high exp %0d got %0d", e.value_high, vh); errors++;
         end
         if (vl !== e.value_low) begin
            $error("value_low exp %0d got %0d", e.value_low, vl); errors++;
         end
         if (dr !== e.distinct_roots) begin
            $error("distinct_roots exp %0b got %0b", e.distinct_roots, dr); errors++;
         end
         if (cn !== e.clamped_negative) begin
            $error("clamped_negative exp %0b got %0b", e.clamped_negative, cn); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   always #6 clock = ~clock;

   eig2_req_if req (clock);
   eig2_rsp_if rsp (clock);
   eig2_csr_if csr (clock);

   eigenvalues_2x2_quadratic_unit DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   eig_scoreboard roots_sb = new();
   bit stall_off = 0;
   int rsp_wait = 0;

   initial begin
      req.valid = 0; req.entry_00 = 0; req.entry_01 = 0; req.entry_10 = 0; req.entry_11 = 0;
      csr.valid = 0; csr.data = 0;
      rsp.ready = 0;
   end

   // Response side: waits a random number of cycles before taking each response.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            roots_sb.check_response(rsp.value_high, rsp.value_low, rsp.distinct_roots,
                                    rsp.clamped_negative);
            rsp_wait = stall_off ? 0 : $urandom_range(0, 7);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp.ready <= (rsp_wait == 0);
      end
   end

   task automatic send_matrix(entry_type e00, entry_type e01, entry_type e10, entry_type e11);
      int gap;
      gap = stall_off ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1;
      req.entry_00 <= e00; req.entry_01 <= e01; req.entry_10 <= e10; req.entry_11 <= e11;
      do @(posedge clock); while (!req.ready);
      roots_sb.note_request(e00, e01, e10, e11);
   endtask

   task automatic drain;
      req.valid <= 0;
      while (roots_sb.pending_roots.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_mode(bit mode);
      csr.valid <= 1;
      csr.data <= mode;
      do @(posedge clock); while (!csr.ready);
      roots_sb.root_mode = mode;
      csr.valid <= 0;
   endtask

   function automatic entry_type rand_entry();
      case ($urandom_range(0, 4))
         0: return $signed($urandom());
         1: return $signed($urandom_range(0, 4095) - 2048) <<< 16;
         2: return $signed($urandom_range(0, 65535) - 32768);
         3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed($urandom_range(0, 511) - 256) <<< 12;
      endcase
   endfunction

   task automatic random_phase(int n);
      entry_type a, b, c, d;
      for (int i = 0; i < n; i++) begin
         a = rand_entry(); b = rand_entry(); c = rand_entry(); d = rand_entry();
         // Symmetric matrices give real, often nonnegative, roots.
         if ($urandom_range(0, 2) == 0) c = b;
         stall_off = (i % 100) > 85;
         send_matrix(a, b, c, d);
      end
      stall_off = 0;
   endtask

   initial begin
      entry_type mx, mn;
      mx = 32'sh7fffffff;
      mn = 32'sh80000000;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int m = 0; m < 2; m++) begin
         if (m == 1) begin
            drain();
            write_mode(1);
         end
         send_matrix(0, 0, 0, 0);
         send_matrix(mx, mx, mx, mx);
         send_matrix(mn, mn, mn, mn);
         send_matrix(mx, mn, mx, mn);
         send_matrix(mn, mx, mn, mx);
         send_matrix(32'sh10000, 0, 0, -32'sh10000);  // distinct, one negative
         send_matrix(32'sh10000, 32'sh10000, -32'sh10000, 32'sh10000); // complex pair
         send_matrix(-32'sh30000, 0, 0, -32'sh30000); // repeated negative
         send_matrix(1, 0, 0, 0);                     // odd difference, q zero
         send_matrix(-1, 0, 0, 0);
         send_matrix(32'sh40000, 32'sh10000, 32'sh10000, 32'sh20000);
      end
      // Hold off until every expected response is back.
      drain();
      write_mode(0);
      random_phase(250);
      drain();
      write_mode(1);
      random_phase(250);
      drain();
      write_mode(0);
      random_phase(250);
      drain();
      if (roots_sb.errors == 0 && roots_sb.pending_roots.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end
endmodule

// File: filelist.f
src/eig2_pkg.sv
src/eig2_if.sv
src/eig2_sqrt_pipe.sv
src/eig2_front.sv
src/eigenvalues_2x2_quadratic_unit.sv
dv/eigenvalues_2x2_quadratic_unit_tb.sv
